### hw/rtl/swc_pkg.sv
// Shared types and constants of the segment window clipper.
// No dependencies; every other file of the block refers to it by scoped names.
package swc_pkg;

	localparam int COORD_BITS     = 32;              // Q16.16 coordinate width
	localparam int DIFF_BITS      = COORD_BITS + 1;  // difference of two coordinates
	localparam int MAG_BITS       = DIFF_BITS;       // magnitude of a difference
	localparam int PROD_BITS      = 2 * MAG_BITS;    // full product of two magnitudes
	localparam int QUO_BITS       = MAG_BITS;        // quotient never exceeds a magnitude
	localparam int SUM_BITS       = MAG_BITS + 1;    // coordinate plus signed quotient
	localparam int NUM_UNITS      = 4;               // start x, start y, end x, end y
	localparam int CFG_INDEX_BITS = 2;
	localparam int STATUS_BITS    = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic        [MAG_BITS-1:0]   mag_t;
	typedef logic        [PROD_BITS-1:0]  prod_t;
	typedef logic        [QUO_BITS-1:0]   quo_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OUTSIDE       = 3'd0,
		ST_INSIDE        = 3'd1,
		ST_START_CLIPPED = 3'd2,
		ST_END_CLIPPED   = 3'd3,
		ST_BOTH_CLIPPED  = 3'd4
	} status_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LEFT   = 2'd0,
		REG_BOTTOM = 2'd1,
		REG_RIGHT  = 2'd2,
		REG_TOP    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROLE_START_X = 2'd0,
		ROLE_START_Y = 2'd1,
		ROLE_END_X   = 2'd2,
		ROLE_END_Y   = 2'd3
	} role_t;

	typedef struct packed {
		coord_t left;
		coord_t bottom;
		coord_t right;
		coord_t top;
	} window_t;

	// one segment in flight: the request as taken, the working endpoints and flags
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
		logic   s1;
		logic   s2;
		logic   rej;
	} item_t;

	// travels alongside the divider
	typedef struct packed {
		item_t  item;
		coord_t bound;
		logic   clip;
		logic   neg;
	} clip_side_t;

endpackage

### hw/rtl/swc_if.sv
// Request and result channels of the segment window clipper.
// Depends on swc_pkg for the coordinate and status types.
interface swc_seg_if;
	logic            valid;
	logic            ready;
	swc_pkg::coord_t start_x;
	swc_pkg::coord_t start_y;
	swc_pkg::coord_t end_x;
	swc_pkg::coord_t end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface swc_res_if;
	logic             valid;
	logic             ready;
	swc_pkg::status_t clip_status;
	swc_pkg::coord_t  out_start_x;
	swc_pkg::coord_t  out_start_y;
	swc_pkg::coord_t  out_end_x;
	swc_pkg::coord_t  out_end_y;

	modport source (output valid, clip_status, out_start_x, out_start_y, out_end_x, out_end_y,
		input ready);
	modport sink   (input valid, clip_status, out_start_x, out_start_y, out_end_x, out_end_y,
		output ready);
endinterface

### hw/rtl/swc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on swc_pkg; the quotient is known to fit QUO_BITS.
module swc_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                op_valid,
	input  swc_pkg::prod_t      op_dividend,
	input  swc_pkg::mag_t       op_divisor,
	input  swc_pkg::clip_side_t op_side,
	output logic                res_valid,
	output swc_pkg::quo_t       res_quotient,
	output swc_pkg::clip_side_t res_side
);

	localparam int N = swc_pkg::QUO_BITS;

	logic [N-1:0]        vld_s;
	swc_pkg::mag_t       rem_s  [N];
	swc_pkg::mag_t       dvs_s  [N];
	swc_pkg::quo_t       lo_s   [N];
	swc_pkg::quo_t       quo_s  [N];
	swc_pkg::clip_side_t side_s [N];

	swc_pkg::mag_t src_rem [N];
	swc_pkg::mag_t src_dvs [N];
	swc_pkg::quo_t src_lo  [N];
	swc_pkg::quo_t src_quo [N];
	swc_pkg::mag_t nxt_rem [N];
	swc_pkg::quo_t nxt_lo  [N];
	swc_pkg::quo_t nxt_quo [N];

	always_comb begin
		logic [swc_pkg::MAG_BITS:0] trial;
		logic [swc_pkg::MAG_BITS:0] diff;
		// top part of the dividend is already below the divisor
		src_rem[0] = op_dividend[swc_pkg::PROD_BITS-1:N];
		src_lo[0]  = op_dividend[N-1:0];
		src_quo[0] = '0;
		src_dvs[0] = op_divisor;
		for (int k = 1; k < N; k++) begin
			src_rem[k] = rem_s[k-1];
			src_lo[k]  = lo_s[k-1];
			src_quo[k] = quo_s[k-1];
			src_dvs[k] = dvs_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			trial = {src_rem[k], src_lo[k][N-1]};
			diff  = trial - {1'b0, src_dvs[k]};
			if (trial >= {1'b0, src_dvs[k]}) begin
				nxt_rem[k] = diff[swc_pkg::MAG_BITS-1:0];
				nxt_quo[k] = {src_quo[k][N-2:0], 1'b1};
			end else begin
				nxt_rem[k] = trial[swc_pkg::MAG_BITS-1:0];
				nxt_quo[k] = {src_quo[k][N-2:0], 1'b0};
			end
			nxt_lo[k] = {src_lo[k][N-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], op_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= op_side;
			for (int k = 1; k < N; k++) begin
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= nxt_rem[k];
				lo_s[k]  <= nxt_lo[k];
				quo_s[k] <= nxt_quo[k];
				dvs_s[k] <= src_dvs[k];
			end
		end
	end

	assign res_valid    = vld_s[N-1];
	assign res_quotient = quo_s[N-1];
	assign res_side     = side_s[N-1];

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N-1] && side_s[N-1].clip |-> rem_s[N-1] < dvs_s[N-1])
		else $error("divider remainder not below divisor on a clipped item");

endmodule

### hw/rtl/swc_clip_unit.sv
// One clipping step: edge test, differences, magnitudes, product, divider, apply.
// Depends on swc_pkg and swc_divider; the role input picks the point and axis.
module swc_clip_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  swc_pkg::role_t   role,
	input  swc_pkg::window_t window,
	input  logic             op_valid,
	input  swc_pkg::item_t   op_item,
	output logic             res_valid,
	output swc_pkg::item_t   res_item
);

	swc_pkg::coord_t c, o, pc, po, lo, hi;
	logic            is_start, below, above, far_out, start_out, rej_now, clip_now;
	swc_pkg::diff_t  e_lo, e_hi;
	swc_pkg::item_t  item_p;

	always_comb begin
		unique case (role)
			swc_pkg::ROLE_START_X: begin
				c = op_item.x1; o = op_item.y1; pc = op_item.x2; po = op_item.y2;
				lo = window.left; hi = window.right;
			end
			swc_pkg::ROLE_START_Y: begin
				c = op_item.y1; o = op_item.x1; pc = op_item.y2; po = op_item.x2;
				lo = window.bottom; hi = window.top;
			end
			swc_pkg::ROLE_END_X: begin
				c = op_item.x2; o = op_item.y2; pc = op_item.x1; po = op_item.y1;
				lo = window.left; hi = window.right;
			end
			swc_pkg::ROLE_END_Y: begin
				c = op_item.y2; o = op_item.x2; pc = op_item.y1; po = op_item.x1;
				lo = window.bottom; hi = window.top;
			end
		endcase
	end

	assign is_start  = (role == swc_pkg::ROLE_START_X) || (role == swc_pkg::ROLE_START_Y);
	assign start_out = (op_item.x1 < window.left) || (op_item.x1 > window.right) ||
		(op_item.y1 < window.bottom) || (op_item.y1 > window.top);
	assign below     = c < lo;
	assign above     = c > hi;
	assign far_out   = below ? (pc < lo) : (pc > hi);
	// clipped start must land in the window before the end point is touched
	assign rej_now   = op_item.rej ||
		((role == swc_pkg::ROLE_END_X) && op_item.s1 && start_out) ||
		(is_start && (below || above) && far_out);
	assign clip_now  = !rej_now && (below || above);
	assign e_lo      = swc_pkg::diff_t'(lo) - swc_pkg::diff_t'(c);
	assign e_hi      = swc_pkg::diff_t'(hi) - swc_pkg::diff_t'(c);

	always_comb begin
		item_p     = op_item;
		item_p.rej = rej_now;
	end

	// stage 1: edge decision and differences
	logic                vld_s1, clip_s1;
	swc_pkg::item_t      item_s1;
	swc_pkg::coord_t     bound_s1;
	swc_pkg::diff_t      d_s1, e_s1, f_s1;
	// stage 2: magnitudes
	logic                vld_s2;
	swc_pkg::clip_side_t side_s2;
	swc_pkg::mag_t       dm_s2, em_s2, fm_s2;
	// stage 3: product
	logic                vld_s3;
	swc_pkg::clip_side_t side_s3;
	swc_pkg::prod_t      prod_s3;
	swc_pkg::mag_t       fm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= op_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= item_p;
			clip_s1  <= clip_now;
			bound_s1 <= below ? lo : hi;
			d_s1     <= swc_pkg::diff_t'(po) - swc_pkg::diff_t'(o);
			e_s1     <= below ? e_lo : e_hi;
			f_s1     <= swc_pkg::diff_t'(pc) - swc_pkg::diff_t'(c);

			side_s2.item  <= item_s1;
			side_s2.bound <= bound_s1;
			side_s2.clip  <= clip_s1;
			side_s2.neg   <= d_s1[swc_pkg::DIFF_BITS-1] ^ e_s1[swc_pkg::DIFF_BITS-1] ^
				f_s1[swc_pkg::DIFF_BITS-1];
			dm_s2 <= d_s1[swc_pkg::DIFF_BITS-1] ? swc_pkg::mag_t'(-d_s1) : swc_pkg::mag_t'(d_s1);
			em_s2 <= e_s1[swc_pkg::DIFF_BITS-1] ? swc_pkg::mag_t'(-e_s1) : swc_pkg::mag_t'(e_s1);
			fm_s2 <= f_s1[swc_pkg::DIFF_BITS-1] ? swc_pkg::mag_t'(-f_s1) : swc_pkg::mag_t'(f_s1);

			side_s3 <= side_s2;
			prod_s3 <= dm_s2 * em_s2;
			fm_s3   <= fm_s2;
		end
	end

	logic                div_valid;
	swc_pkg::quo_t       div_quo;
	swc_pkg::clip_side_t div_side;

	swc_divider u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.op_valid     (vld_s3),
		.op_dividend  (prod_s3),
		.op_divisor   (fm_s3),
		.op_side      (side_s3),
		.res_valid    (div_valid),
		.res_quotient (div_quo),
		.res_side     (div_side)
	);

	// apply: other coordinate moves by the signed quotient, clipped one lands on the edge
	swc_pkg::item_t item_w;

	always_comb begin
		swc_pkg::coord_t oa;
		swc_pkg::sum_t   qx;
		swc_pkg::sum_t   sum;
		swc_pkg::coord_t o_new;
		unique case (role)
			swc_pkg::ROLE_START_X: oa = div_side.item.y1;
			swc_pkg::ROLE_START_Y: oa = div_side.item.x1;
			swc_pkg::ROLE_END_X:   oa = div_side.item.y2;
			swc_pkg::ROLE_END_Y:   oa = div_side.item.x2;
		endcase
		qx     = swc_pkg::sum_t'({1'b0, div_quo});
		sum    = div_side.neg ? (swc_pkg::sum_t'(oa) - qx) : (swc_pkg::sum_t'(oa) + qx);
		o_new  = sum[swc_pkg::COORD_BITS-1:0];
		item_w = div_side.item;
		if (div_side.clip) begin
			unique case (role)
				swc_pkg::ROLE_START_X: begin
					item_w.x1 = div_side.bound; item_w.y1 = o_new; item_w.s1 = 1'b1;
				end
				swc_pkg::ROLE_START_Y: begin
					item_w.y1 = div_side.bound; item_w.x1 = o_new; item_w.s1 = 1'b1;
				end
				swc_pkg::ROLE_END_X: begin
					item_w.x2 = div_side.bound; item_w.y2 = o_new; item_w.s2 = 1'b1;
				end
				swc_pkg::ROLE_END_Y: begin
					item_w.y2 = div_side.bound; item_w.x2 = o_new; item_w.s2 = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_item <= item_w;
		end
	end

	a_start_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && side_s3.clip && is_start |-> fm_s3 != '0)
		else $error("start point clip with zero divisor");

endmodule

### hw/rtl/segment_window_clip.sv
// Segment window clipper, top level: window registers, four clip units, result register.
// Depends on swc_pkg, swc_if, swc_clip_unit and swc_divider.
//
// Clips one segment per request against the inclusive window held in the four
// window registers (Q16.16, reset 0), start point first (x then y), then the end
// point (x then y). A new request is taken every cycle unless the pipeline holds.
// Each clip unit has a restoring divider that settles one quotient bit per stage,
// behind three stages of edge test, magnitude and multiply and ahead of one apply
// stage. The whole pipeline moves together; it holds only while a result sits
// unaccepted on the result channel and the pipeline tail is occupied, and a bubble
// at the tail lets new requests in even then. Rejected segments come back with
// status outside and their endpoints as requested. The user must write the window
// registers only while idle; the block itself does not enforce it.

module segment_window_clip (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [swc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [swc_pkg::COORD_BITS-1:0]      cfg_data,
	swc_seg_if.sink                             segment,
	swc_res_if.source                           result
);

	localparam int NU = swc_pkg::NUM_UNITS;

	swc_pkg::window_t window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (swc_pkg::cfg_reg_t'(cfg_index))
				swc_pkg::REG_LEFT:   window_q.left   <= swc_pkg::coord_t'(cfg_data);
				swc_pkg::REG_BOTTOM: window_q.bottom <= swc_pkg::coord_t'(cfg_data);
				swc_pkg::REG_RIGHT:  window_q.right  <= swc_pkg::coord_t'(cfg_data);
				swc_pkg::REG_TOP:    window_q.top    <= swc_pkg::coord_t'(cfg_data);
			endcase
		end
	end

	// global advance: result register free, or nothing at the pipeline tail
	logic           out_ok, advance;
	logic           chain_valid [NU+1];
	swc_pkg::item_t chain_item  [NU+1];

	assign out_ok        = !result.valid || result.ready;
	assign advance       = out_ok || !chain_valid[NU];
	assign segment.ready = advance;

	always_comb begin
		chain_item[0]         = '0;
		chain_item[0].start_x = segment.start_x;
		chain_item[0].start_y = segment.start_y;
		chain_item[0].end_x   = segment.end_x;
		chain_item[0].end_y   = segment.end_y;
		chain_item[0].x1      = segment.start_x;
		chain_item[0].y1      = segment.start_y;
		chain_item[0].x2      = segment.end_x;
		chain_item[0].y2      = segment.end_y;
	end
	assign chain_valid[0] = segment.valid;

	for (genvar k = 0; k < NU; k++) begin : g_unit
		swc_clip_unit u_clip (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.role      (swc_pkg::role_t'(k)),
			.window    (window_q),
			.op_valid  (chain_valid[k]),
			.op_item   (chain_item[k]),
			.res_valid (chain_valid[k+1]),
			.res_item  (chain_item[k+1])
		);
	end

	swc_pkg::item_t   fin;
	swc_pkg::status_t fin_status;

	assign fin = chain_item[NU];

	always_comb begin
		if (fin.rej) begin
			fin_status = swc_pkg::ST_OUTSIDE;
		end else begin
			unique case ({fin.s1, fin.s2})
				2'b00: fin_status = swc_pkg::ST_INSIDE;
				2'b10: fin_status = swc_pkg::ST_START_CLIPPED;
				2'b01: fin_status = swc_pkg::ST_END_CLIPPED;
				2'b11: fin_status = swc_pkg::ST_BOTH_CLIPPED;
			endcase
		end
	end

	logic             res_valid_q;
	swc_pkg::status_t res_status_q;
	swc_pkg::coord_t  res_sx_q, res_sy_q, res_ex_q, res_ey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ok) begin
			res_valid_q <= chain_valid[NU];
		end
	end

	// outside: endpoints go back as requested
	always_ff @(posedge clk) begin
		if (out_ok && chain_valid[NU]) begin
			res_status_q <= fin_status;
			res_sx_q     <= fin.rej ? fin.start_x : fin.x1;
			res_sy_q     <= fin.rej ? fin.start_y : fin.y1;
			res_ex_q     <= fin.rej ? fin.end_x   : fin.x2;
			res_ey_q     <= fin.rej ? fin.end_y   : fin.y2;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.clip_status = res_status_q;
	assign result.out_start_x = res_sx_q;
	assign result.out_start_y = res_sy_q;
	assign result.out_end_x   = res_ex_q;
	assign result.out_end_y   = res_ey_q;

	a_no_end_clip_after_reject: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[NU] && fin.rej |-> !fin.s2)
		else $error("end point clipped on a rejected segment");

	a_unclipped_start_kept: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[NU] && !fin.s1 |-> (fin.x1 == fin.start_x) && (fin.y1 == fin.start_y))
		else $error("start point moved without a start clip");

endmodule
